// ----- hw/rtl/hst_pkg.sv -----
`default_nettype none

package hst_pkg;

  // default capacity of the table
  localparam int unsigned SlotsDefault = 64;

  // fixed field widths
  localparam int unsigned ReqTypeW  = 2;
  localparam int unsigned HandleW   = 17;
  localparam int unsigned PosW      = 6;
  localparam int unsigned ObjW      = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned LiveCntW  = 7;
  localparam int unsigned BaseW     = 16;

  // request codes
  localparam logic [ReqTypeW-1:0] REQ_ADD           = 2'd0;
  localparam logic [ReqTypeW-1:0] REQ_REMOVE        = 2'd1;
  localparam logic [ReqTypeW-1:0] REQ_LOOKUP_HANDLE = 2'd2;
  localparam logic [ReqTypeW-1:0] REQ_LOOKUP_POS    = 2'd3;

  // status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd2;
  localparam logic [StatusW-1:0] ST_ZERO  = 2'd3;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [HandleW-1:0]  handle_in;
    logic [PosW-1:0]     slot_position;
    logic [ObjW-1:0]     object_in;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [HandleW-1:0]  handle_out;
    logic [ObjW-1:0]     object_out;
    logic [LiveCntW-1:0] live_count;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/handle_slot_table.sv -----
// a request is captured with its slot memory read at accept; the result word is registered at completion
// the table takes no new request until the last one completes: slot memory read, then writeback
// a result waiting on a stalled output holds the next request in its read phase
// reset clears the occupancy bitmap, the live count and the handle base;
// the slot memory itself is not cleared, a slot without its occupancy bit reads as zero
`default_nettype none

module handle_slot_table #(
  parameter int unsigned SLOTS = hst_pkg::SlotsDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // request channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire hst_pkg::req_t             in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output hst_pkg::rsp_t                  out_data_o,
  // handle base register write
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [hst_pkg::BaseW-1:0] cfg_data_i
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // configuration
  logic [hst_pkg::BaseW-1:0] base_q;

  // occupancy bitmap doubles as the valid bits of the slot memory
  logic [SLOTS-1:0] occ_q, occ_d;
  logic [CW-1:0]    count_q, count_d;

  // slot memory and its registered read port
  logic [hst_pkg::ObjW-1:0] slot_mem_q [SLOTS];
  logic [hst_pkg::ObjW-1:0] rdata_q;

  // request held during the read phase
  logic                          busy_q;
  logic [hst_pkg::ReqTypeW-1:0]  req_q;
  logic [AW-1:0]                 addr_q;
  logic [hst_pkg::HandleW-1:0]   hout_q;
  logic [hst_pkg::StatusW-1:0]   st_q;
  logic [hst_pkg::ObjW-1:0]      obj_q;

  // output register
  logic          out_valid_q;
  hst_pkg::rsp_t out_q;

  logic accept, complete;

  // lowest free slot, priority encoded from the bitmap
  logic [AW-1:0] free_idx;
  logic          table_full;

  // handle to slot translation
  logic [hst_pkg::HandleW:0]   hdiff;
  logic                        h_in_range;
  logic                        pos_in_range;
  logic [hst_pkg::HandleW-1:0] pos_ext;

  // accept-phase decode
  logic [AW-1:0]                addr_d;
  logic [hst_pkg::HandleW-1:0]  hout_d;
  logic [hst_pkg::StatusW-1:0]  st_d;
  logic                         slot_ok;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign accept      = in_valid_i && !busy_q;
  assign complete    = busy_q && (!out_valid_q || !out_stall_i);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    free_idx   = '0;
    table_full = &occ_q;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!occ_q[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  // borrow out of the subtract means the handle sits below the base
  assign hdiff        = {1'b0, in_data_i.handle_in} - (hst_pkg::HandleW + 1)'(base_q);
  assign h_in_range   = !hdiff[hst_pkg::HandleW] &&
                        (hdiff[hst_pkg::HandleW-1:0] < hst_pkg::HandleW'(SLOTS));
  assign pos_ext      = hst_pkg::HandleW'(in_data_i.slot_position);
  assign pos_in_range = pos_ext < hst_pkg::HandleW'(SLOTS);

  // status is settled at accept: the bitmap cannot move while a request is in flight
  always_comb begin
    addr_d  = '0;
    hout_d  = '0;
    st_d    = hst_pkg::ST_OK;
    slot_ok = 1'b0;
    case (in_data_i.req_type)
      hst_pkg::REQ_ADD: begin
        addr_d = free_idx;
        if (in_data_i.object_in == '0) begin
          st_d = hst_pkg::ST_ZERO;
        end else if (table_full) begin
          st_d = hst_pkg::ST_FULL;
        end else begin
          hout_d = hst_pkg::HandleW'(base_q) + hst_pkg::HandleW'(free_idx);
        end
      end
      hst_pkg::REQ_REMOVE, hst_pkg::REQ_LOOKUP_HANDLE: begin
        addr_d  = hdiff[AW-1:0];
        hout_d  = in_data_i.handle_in;
        slot_ok = h_in_range && occ_q[hdiff[AW-1:0]];
        st_d    = slot_ok ? hst_pkg::ST_OK : hst_pkg::ST_RANGE;
      end
      hst_pkg::REQ_LOOKUP_POS: begin
        addr_d  = pos_ext[AW-1:0];
        if (pos_in_range) begin
          hout_d = hst_pkg::HandleW'(base_q) + pos_ext;
        end
        slot_ok = pos_in_range && occ_q[pos_ext[AW-1:0]];
        st_d    = slot_ok ? hst_pkg::ST_OK : hst_pkg::ST_RANGE;
      end
      default: begin
        st_d = hst_pkg::ST_RANGE;
      end
    endcase
  end

  // writeback phase: commit an add or remove that passed its checks to the bitmap and live count
  always_comb begin
    occ_d   = occ_q;
    count_d = count_q;
    if (st_q == hst_pkg::ST_OK) begin
      case (req_q)
        hst_pkg::REQ_ADD: begin
          occ_d[addr_q] = 1'b1;
          count_d       = count_q + CW'(1);
        end
        hst_pkg::REQ_REMOVE: begin
          occ_d[addr_q] = 1'b0;
          count_d       = count_q - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      occ_q       <= '0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (complete) begin
        busy_q <= 1'b0;
      end
      if (complete) begin
        occ_q       <= occ_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request payload held for the writeback phase
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_data_i.req_type;
      addr_q <= addr_d;
      hout_q <= hout_d;
      st_q   <= st_d;
      obj_q  <= in_data_i.object_in;
    end
  end

  // slot memory: read at accept, written at completion of a good add
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= slot_mem_q[addr_d];
    end
    if (complete && req_q == hst_pkg::REQ_ADD && st_q == hst_pkg::ST_OK) begin
      slot_mem_q[addr_q] <= obj_q;
    end
  end

  // result word; lookups return the stored word only for an occupied slot
  always_ff @(posedge clk_i) begin
    if (complete) begin
      out_q.status     <= st_q;
      out_q.handle_out <= hout_q;
      out_q.live_count <= hst_pkg::LiveCntW'(count_d);
      if ((req_q == hst_pkg::REQ_LOOKUP_HANDLE || req_q == hst_pkg::REQ_LOOKUP_POS) &&
          st_q == hst_pkg::ST_OK) begin
        out_q.object_out <= rdata_q;
      end else begin
        out_q.object_out <= '0;
      end
    end
  end

endmodule

`default_nettype wire
